### sv/tlmd_pkg.sv
`default_nettype none

package tlmd_pkg;

    // parser phase: type byte, length high, length low, payload
    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN_HI  = 2'd1,
        PH_LEN_LO  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    // event code reported with every result
    typedef enum logic [2:0] {
        EV_HEADER     = 3'd0,
        EV_PAYLOAD    = 3'd1,
        EV_EMPTY_DONE = 3'd2,
        EV_LEN_ERROR  = 3'd3,
        EV_DROPPED    = 3'd4
    } t_event;

    // configuration register indexes
    localparam logic CFG_MARKER_TYPE = 1'b0;
    localparam logic CFG_MAX_LENGTH  = 1'b1;

    localparam logic [7:0]  MARKER_TYPE_RST = 8'd0;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;

    localparam int TDATA_W = 72;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  msg_type;
        logic [15:0] msg_length;
        logic [7:0]  payload_byte;
        logic        message_last;
        logic        marker_seen;
        logic [15:0] messages_received;
        logic [15:0] errors_counted;
    } t_result;

endpackage

`default_nettype wire

### sv/tlmd_parser.sv
`default_nettype none

module tlmd_parser (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_step,
    input  wire  [7:0]       i_byte,
    input  wire              i_packet_end,
    input  wire  [7:0]       i_marker_type,
    input  wire  [15:0]      i_max_length,
    output tlmd_pkg::t_result o_result
);

    tlmd_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_length, n_length;
    logic [15:0] r_pos, n_pos;
    logic        r_drop, n_drop;
    logic [15:0] r_msg_cnt, n_msg_cnt;
    logic [15:0] r_err_cnt, n_err_cnt;

    logic [15:0] w_full_len;
    logic [15:0] w_pos_inc;
    logic        w_len_err;
    logic        w_finish;

    assign w_full_len = {r_length[15:8], i_byte};
    assign w_pos_inc  = r_pos + 16'd1;
    assign w_len_err  = (w_full_len > i_max_length);

    // a message completes on an empty length or on its last payload byte
    always_comb begin
        w_finish = 1'b0;
        if (!r_drop) begin
            case (r_phase)
                tlmd_pkg::PH_LEN_LO:  w_finish = !w_len_err && (w_full_len == 16'd0);
                tlmd_pkg::PH_PAYLOAD: w_finish = (w_pos_inc >= r_length);
                default:              w_finish = 1'b0;
            endcase
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (!r_drop) begin
            case (r_phase)
                tlmd_pkg::PH_TYPE:   n_phase = tlmd_pkg::PH_LEN_HI;
                tlmd_pkg::PH_LEN_HI: n_phase = tlmd_pkg::PH_LEN_LO;
                tlmd_pkg::PH_LEN_LO: begin
                    if (w_len_err || w_finish) begin
                        n_phase = tlmd_pkg::PH_TYPE;
                    end else begin
                        n_phase = tlmd_pkg::PH_PAYLOAD;
                    end
                end
                tlmd_pkg::PH_PAYLOAD: begin
                    if (w_finish) begin
                        n_phase = tlmd_pkg::PH_TYPE;
                    end
                end
                default: n_phase = tlmd_pkg::PH_TYPE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_type    = r_type;
        n_length  = r_length;
        n_pos     = r_pos;
        n_drop    = r_drop;
        n_msg_cnt = r_msg_cnt;
        n_err_cnt = r_err_cnt;
        o_result.event_res    = tlmd_pkg::EV_HEADER;
        o_result.payload_byte = 8'd0;
        o_result.message_last = 1'b0;
        o_result.marker_seen  = 1'b0;
        if (r_drop) begin
            o_result.event_res = tlmd_pkg::EV_DROPPED;
        end else begin
            case (r_phase)
                tlmd_pkg::PH_TYPE: begin
                    n_type = i_byte;
                    n_pos  = 16'd0;
                end
                tlmd_pkg::PH_LEN_HI: begin
                    n_length = {i_byte, 8'd0};
                end
                tlmd_pkg::PH_LEN_LO: begin
                    n_length = w_full_len;
                    if (w_len_err) begin
                        o_result.event_res = tlmd_pkg::EV_LEN_ERROR;
                        if (r_err_cnt != 16'hFFFF) begin
                            n_err_cnt = r_err_cnt + 16'd1;
                        end
                    end else if (w_finish) begin
                        o_result.event_res = tlmd_pkg::EV_EMPTY_DONE;
                    end
                end
                tlmd_pkg::PH_PAYLOAD: begin
                    o_result.event_res    = tlmd_pkg::EV_PAYLOAD;
                    o_result.payload_byte = i_byte;
                    n_pos                 = w_pos_inc;
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
            if (w_finish) begin
                o_result.message_last = 1'b1;
                if (r_msg_cnt != 16'hFFFF) begin
                    n_msg_cnt = r_msg_cnt + 16'd1;
                end
                if (r_type == i_marker_type) begin
                    o_result.marker_seen = 1'b1;
                    n_drop               = 1'b1;
                end
            end
        end
        if (i_packet_end) begin
            n_drop = 1'b0;
        end
        o_result.msg_type          = n_type;
        o_result.msg_length        = n_length;
        o_result.messages_received = n_msg_cnt;
        o_result.errors_counted    = n_err_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= tlmd_pkg::PH_TYPE;
            r_type    <= 8'd0;
            r_length  <= 16'd0;
            r_pos     <= 16'd0;
            r_drop    <= 1'b0;
            r_msg_cnt <= 16'd0;
            r_err_cnt <= 16'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_length  <= n_length;
            r_pos     <= n_pos;
            r_drop    <= n_drop;
            r_msg_cnt <= n_msg_cnt;
            r_err_cnt <= n_err_cnt;
        end
    end

endmodule

`default_nettype wire

### sv/type_length_message_deframer.sv
// an input transfer passes the input register, then the result register
// throughput: one byte per cycle while the master side accepts, with the
// parser state update between the input register and the result register
// reset: synchronous active-low i_rst_n clears the parser, counters and
// both pipeline valids; marker_type returns to 0 and max_length to 1024
`default_nettype none

module type_length_message_deframer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration writes
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    // received byte stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  wire         s_axis_tlast,   // packet_end
    // parse results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // event_res[2:0], msg_type[10:3], msg_length[26:11], payload_byte[34:27],
    // messages_received[50:35], errors_counted[66:51], zero fill[71:67]
    output logic [tlmd_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast,   // message_last
    output logic        m_axis_tuser    // marker_seen
);

    // configuration registers
    logic [7:0]  r_marker_type;
    logic [15:0] r_max_length;

    // input register stage
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // result register stage
    logic              r_out_vld;
    tlmd_pkg::t_result r_out;
    tlmd_pkg::t_result w_result;

    logic w_step;
    logic w_in_xfer;

    // the staged byte moves on when the result register is empty or drains now
    assign w_step        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_step;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_type <= tlmd_pkg::MARKER_TYPE_RST;
            r_max_length  <= tlmd_pkg::MAX_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tlmd_pkg::CFG_MARKER_TYPE: r_marker_type <= i_cfg_data[7:0];
                tlmd_pkg::CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                default:                   r_max_length  <= r_max_length;
            endcase
        end
    end

    // input stage: valid tracks occupancy, payload loads on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (w_step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // parser state advances only when the staged byte is consumed
    tlmd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_byte        (r_in_byte),
        .i_packet_end  (r_in_last),
        .i_marker_type (r_marker_type),
        .i_max_length  (r_max_length),
        .o_result      (w_result)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0,
                            r_out.errors_counted,
                            r_out.messages_received,
                            r_out.payload_byte,
                            r_out.msg_length,
                            r_out.msg_type,
                            r_out.event_res};
    assign m_axis_tlast  = r_out.message_last;
    assign m_axis_tuser  = r_out.marker_seen;

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 100_000;

    // predicts the deframer result for every accepted byte and checks the
    // results leaving the master side in order
    class deframer_scoreboard;
        logic [7:0]        marker;
        logic [15:0]       max_len;
        tlmd_pkg::t_phase  phase;
        logic [7:0]        cur_type;
        logic [15:0]       cur_len;
        logic [15:0]       pos;
        logic              dropping;
        logic [15:0]       msg_count;
        logic [15:0]       err_count;
        tlmd_pkg::t_result pending_results[$];
        int                noted;
        int                failures;
        int                results_seen;
        int                event_tally[5];

        function new();
            marker    = tlmd_pkg::MARKER_TYPE_RST;
            max_len   = tlmd_pkg::MAX_LENGTH_RST;
            phase     = tlmd_pkg::PH_TYPE;
            cur_type  = '0;
            cur_len   = '0;
            pos       = '0;
            dropping  = 1'b0;
            msg_count = '0;
            err_count = '0;
        endfunction

        function void set_reg(logic idx, logic [15:0] data);
            if (idx == tlmd_pkg::CFG_MARKER_TYPE) begin
                marker = data[7:0];
            end else begin
                max_len = data;
            end
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        // message completed: count it and arm the drop when it is the marker
        function logic close_message();
            msg_count = bump(msg_count);
            phase     = tlmd_pkg::PH_TYPE;
            if (cur_type == marker) begin
                dropping = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic pend);
            tlmd_pkg::t_result r;
            r = '0;
            r.event_res = tlmd_pkg::EV_HEADER;
            if (dropping) begin
                r.event_res = tlmd_pkg::EV_DROPPED;
            end else begin
                case (phase)
                    tlmd_pkg::PH_TYPE: begin
                        cur_type = b;
                        pos      = '0;
                        phase    = tlmd_pkg::PH_LEN_HI;
                    end
                    tlmd_pkg::PH_LEN_HI: begin
                        cur_len = {b, 8'h00};
                        phase   = tlmd_pkg::PH_LEN_LO;
                    end
                    tlmd_pkg::PH_LEN_LO: begin
                        cur_len = {cur_len[15:8], b};
                        if (cur_len > max_len) begin
                            err_count   = bump(err_count);
                            phase       = tlmd_pkg::PH_TYPE;
                            r.event_res = tlmd_pkg::EV_LEN_ERROR;
                        end else if (cur_len != 16'd0) begin
                            phase = tlmd_pkg::PH_PAYLOAD;
                        end else begin
                            r.event_res    = tlmd_pkg::EV_EMPTY_DONE;
                            r.message_last = 1'b1;
                            r.marker_seen  = close_message();
                        end
                    end
                    default: begin
                        r.event_res    = tlmd_pkg::EV_PAYLOAD;
                        r.payload_byte = b;
                        pos            = pos + 16'd1;
                        if (pos >= cur_len) begin
                            r.message_last = 1'b1;
                            r.marker_seen  = close_message();
                        end
                    end
                endcase
            end
            // packet end always releases the drop, even for a marker just finished
            if (pend) dropping = 1'b0;
            r.msg_type          = cur_type;
            r.msg_length        = cur_len;
            r.messages_received = msg_count;
            r.errors_counted    = err_count;
            pending_results.insert(pending_results.size(), r);
            event_tally[r.event_res]++;
            noted++;
        endfunction

        function void check_result(logic [tlmd_pkg::TDATA_W-1:0] d, logic lst, logic usr);
            tlmd_pkg::t_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected transfer on result side: tdata=%h last=%b user=%b",
                             d, lst, usr);
                return;
            end
            want = pending_results.pop_front();
            if (d[2:0] !== want.event_res || d[10:3] !== want.msg_type ||
                d[26:11] !== want.msg_length || d[34:27] !== want.payload_byte ||
                d[50:35] !== want.messages_received || d[66:51] !== want.errors_counted ||
                lst !== want.message_last || usr !== want.marker_seen) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch %0d want: ev=%0d type=%h len=%h pay=%h",
                             failures, want.event_res, want.msg_type, want.msg_length,
                             want.payload_byte);
                    $display("    want: last=%b mark=%b msgs=%0d errs=%0d",
                             want.message_last, want.marker_seen,
                             want.messages_received, want.errors_counted);
                    $display("    got:  ev=%0d type=%h len=%h pay=%h",
                             d[2:0], d[10:3], d[26:11], d[34:27]);
                    $display("    got:  last=%b mark=%b msgs=%0d errs=%0d",
                             lst, usr, d[50:35], d[66:51]);
                end
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic                          i_cfg_index;
    logic [15:0]                   i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata;   // rx_byte[7:0]
    logic                          s_axis_tlast;   // packet_end
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // event_res[2:0], msg_type[10:3], msg_length[26:11], payload_byte[34:27],
    // messages_received[50:35], errors_counted[66:51], zero fill[71:67]
    logic [tlmd_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                          m_axis_tlast;   // message_last
    logic                          m_axis_tuser;   // marker_seen

    deframer_scoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    logic hold_rx;
    int  cycle_count;
    int  cfg_writes;

    type_length_message_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: sample the transfer at the edge, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
    end

    // one byte transfer on the slave side, with random gaps in front of it
    task automatic send_byte(input logic [7:0] b, input logic pend);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= pend;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, pend);
    endtask

    // config writes happen only with the pipeline empty
    task automatic write_reg(input logic idx, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        cfg_writes++;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering bytes and wait until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic hold_receiver(input int cycles);
        hold_rx <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_rx <= 1'b0;
    endtask

    function automatic logic pick_packet_end();
        return $urandom_range(99) < 10;
    endfunction

    // mostly short legal lengths, some empty, some over the limit
    function automatic int pick_length();
        int r;
        int mx;
        int cap;
        r  = $urandom_range(99);
        mx = sb.max_len;
        if (r < 12) return 0;
        if (r < 24 && mx < 65535) return $urandom_range(65535, mx + 1);
        if (r < 30 && mx <= 12) return mx;
        cap = (mx < 8) ? mx : 8;
        if (cap == 0) return 0;
        return $urandom_range(cap, 1);
    endfunction

    // well-formed messages with random content, plus stray bytes and
    // messages cut short so the next header lands inside the payload
    task automatic random_stream(input int target);
        int   goal;
        int   kind;
        int   len;
        int   cut;
        logic [7:0] mtype;
        goal = sb.noted + target;
        while (sb.noted < goal) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                send_byte(8'($urandom), pick_packet_end());
            end else begin
                mtype = ($urandom_range(3) == 0) ? sb.marker : 8'($urandom);
                len   = pick_length();
                send_byte(mtype, pick_packet_end());
                send_byte(len[15:8], pick_packet_end());
                send_byte(len[7:0], pick_packet_end());
                if (len <= sb.max_len) begin
                    cut = (kind < 16) ? $urandom_range(len) : len;
                    repeat (cut) send_byte(8'($urandom), pick_packet_end());
                end
            end
        end
    endtask

    // directed bytes as {packet_end, byte}; max_length is 3, marker is a5
    logic [8:0] script [24] = '{
        9'h000, 9'h000, 9'h000,                          // empty message, all zeros
        9'h0ff, 9'h000, 9'h003, 9'h0ff, 9'h100, 9'h080,  // length at max, packet ends mid-payload
        9'h011, 9'h000, 9'h004,                          // one over max
        9'h022, 9'h0ff, 9'h0ff,                          // largest length field
        9'h0a5, 9'h000, 9'h001, 9'h033, 9'h077, 9'h188,  // marker, rest of packet dropped
        9'h0a5, 9'h000, 9'h100                           // marker on packet end, nothing dropped
    };

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= tlmd_pkg::CFG_MARKER_TYPE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        hold_rx       <= 1'b0;
        cycle_count   <= 0;
        cfg_writes    = 0;
        tx_idle_pct   = 22;
        rx_idle_pct   = 58;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases
        write_reg(tlmd_pkg::CFG_MARKER_TYPE, 16'h00a5);
        write_reg(tlmd_pkg::CFG_MAX_LENGTH, 16'd3);
        foreach (script[k]) send_byte(script[k][7:0], script[k][8]);
        drain();

        // sender light, receiver heavy idling
        write_reg(tlmd_pkg::CFG_MARKER_TYPE, 16'($urandom_range(255)));
        write_reg(tlmd_pkg::CFG_MAX_LENGTH, 16'($urandom_range(20, 1)));
        random_stream(300);
        drain();
        write_reg(tlmd_pkg::CFG_MARKER_TYPE, 16'h00ff);
        write_reg(tlmd_pkg::CFG_MAX_LENGTH, 16'd0);
        random_stream(200);
        drain();

        // roles swapped
        tx_idle_pct = 58;
        rx_idle_pct = 22;
        write_reg(tlmd_pkg::CFG_MARKER_TYPE, 16'h0000);
        write_reg(tlmd_pkg::CFG_MAX_LENGTH, 16'hffff);
        random_stream(250);
        drain();
        write_reg(tlmd_pkg::CFG_MARKER_TYPE, 16'($urandom_range(255)));
        write_reg(tlmd_pkg::CFG_MAX_LENGTH, 16'($urandom_range(12, 2)));
        random_stream(250);
        drain();

        // full rate, with a long receiver stall so the input backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(tlmd_pkg::CFG_MARKER_TYPE, 16'($urandom_range(255)));
        write_reg(tlmd_pkg::CFG_MAX_LENGTH, 16'd1024);
        fork
            random_stream(550);
            hold_receiver(300);
        join
        drain();

        $display("run covered %0d bytes, %0d results, %0d config writes",
                 sb.noted, sb.results_seen, cfg_writes);
        $display("events: header %0d payload %0d empty %0d len err %0d dropped %0d",
                 sb.event_tally[tlmd_pkg::EV_HEADER], sb.event_tally[tlmd_pkg::EV_PAYLOAD],
                 sb.event_tally[tlmd_pkg::EV_EMPTY_DONE],
                 sb.event_tally[tlmd_pkg::EV_LEN_ERROR],
                 sb.event_tally[tlmd_pkg::EV_DROPPED]);
        if (sb.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/tlmd_pkg.sv
sv/tlmd_parser.sv
sv/type_length_message_deframer.sv
sim/testbench.sv
